FILE: rtl/hpc_pkg.sv
// shared types and constants for the headset pose to camera transform
`timescale 1ns / 1ps
package hpc_pkg;
    localparam int FRAC = 16;
    localparam logic [30:0] UPM_RESET = 31'(69) << FRAC;
    localparam logic [30:0] TELEPORT_RESET = 31'(100) << FRAC;

    typedef enum logic [2:0] {
        OP_LOAD_POSE = 3'd0,
        OP_LOAD_CAM  = 3'd1,
        OP_COMPUTE   = 3'd2,
        OP_RESET_BASE = 3'd3,
        OP_RECAL     = 3'd4
    } opcode_t;

    typedef enum logic {
        REG_UPM = 1'b0,
        REG_TELEPORT = 1'b1
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIST, ST_CHECK, ST_REMAP, ST_SCALE, ST_MAC, ST_ROUND, ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic       load_pose;
        logic       load_cam;
        logic       clr_base;
        logic       clr_height;
        logic       dist_step;   // accumulate one axis of teleport distance
        logic       dist_clr;
        logic       capture;     // conditional base capture
        logic       remap;       // axis remap and height latch, one row per step
        logic       scale;       // one translation axis per step
        logic       mac_clr;
        logic       mac_step;
        logic       round_res;
        logic [1:0] sub;         // axis counter within a step group
        logic [3:0] res_idx;     // output element being computed
    } ctrl_t;

    typedef struct packed {
        logic moved;
    } stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage

FILE: rtl/hpc_datapath.sv
// buffers, shared multiplier and accumulator for the transform
`timescale 1ns / 1ps
module hpc_datapath
    import hpc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  ctrl_t              ctrl,
    input  logic [3:0]         idx,
    input  logic signed [31:0] value,
    input  logic [30:0]        upm,
    input  logic [30:0]        teleport,
    output stat_t              stat,
    output logic signed [31:0] res_value
);
    logic signed [31:0] pose_reg [12];
    logic signed [31:0] cam_reg [12];
    logic signed [31:0] base_reg [12];
    logic signed [31:0] hrot_reg [9];
    logic signed [31:0] htr_reg [3];
    logic               base_valid_reg, height_latched_reg;
    logic signed [31:0] refh_reg;
    logic [65:0]        dist_reg;
    logic signed [65:0] acc_reg;
    logic signed [31:0] res_reg;
    logic signed [65:0] prod;
    logic signed [32:0] d;
    logic [32:0]        dm;
    logic [1:0]         k;
    logic [3:0]         r;
    logic [3:0]         rb, col;
    logic signed [31:0] ma, mb;
    logic signed [65:0] acc_next, rnd;
    logic signed [32:0] pa, delta;
    logic signed [31:0] dsat;

    assign k = ctrl.sub;
    assign d = 33'(cam_reg[4'd9 + 4'(k)]) - 33'(base_reg[4'd9 + 4'(k)]);
    assign dm = d[32] ? 33'(-d) : d;
    assign stat.moved = !base_valid_reg || (dist_reg > 66'(teleport) * 66'(teleport));
    assign delta = 33'(pose_reg[7]) - 33'(height_latched_reg ? refh_reg : pose_reg[7]);
    assign dsat = sat32(66'(delta));

    // multiplier operand selection
    always_comb begin
        r = ctrl.res_idx;
        // start of the base rotation row for this output element
        if (r < 4'd3 || r == 4'd9) rb = 4'd0;
        else if (r < 4'd6 || r == 4'd10) rb = 4'd3;
        else rb = 4'd6;
        col = r - rb;
        ma = '0;
        mb = '0;
        if (ctrl.scale) begin
            ma = (k == 2'd0) ? pose_reg[3] : (k == 2'd1) ? pose_reg[11] : dsat;
            mb = $signed({1'b0, upm});
        end else if (r < 4'd9) begin
            ma = base_reg[rb + 4'(k)];
            mb = hrot_reg[4'(k) * 4'd3 + col];
        end else begin
            ma = base_reg[rb + 4'(k)];
            mb = (k == 2'd3) ? 32'sh0 : htr_reg[k];
        end
    end

    always_comb begin
        pa = 33'(ma);
        if (ctrl.scale && k == 2'd1) pa = -pa;
        prod = 66'(pa) * 66'(mb);
        acc_next = acc_reg + prod;
        if (ctrl.mac_step && ctrl.res_idx >= 4'd9 && k == 2'd3)
            acc_next = acc_reg + (66'(base_reg[ctrl.res_idx]) <<< FRAC);
        rnd = (acc_reg + (66'sd1 <<< (FRAC - 1))) >>> FRAC;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_pose) pose_reg[idx] <= value;
        if (ctrl.load_cam) cam_reg[idx] <= value;
        if (ctrl.dist_clr) dist_reg <= '0;
        else if (ctrl.dist_step) dist_reg <= dist_reg + 66'(dm) * 66'(dm);
        if (ctrl.mac_clr) acc_reg <= '0;
        else if (ctrl.mac_step || ctrl.scale) acc_reg <= ctrl.scale ? prod : acc_next;
        if (ctrl.round_res) res_reg <= sat32(rnd);
        if (ctrl.remap) begin
            hrot_reg[4'(k) * 4'd3 + 4'd0] <= pose_reg[4'(k) * 4'd4 + 4'd0];
            hrot_reg[4'(k) * 4'd3 + 4'd1] <= sat32(-66'(pose_reg[4'(k) * 4'd4 + 4'd2]));
            hrot_reg[4'(k) * 4'd3 + 4'd2] <= pose_reg[4'(k) * 4'd4 + 4'd1];
        end
        if (ctrl.round_res && ctrl.scale) htr_reg[k] <= sat32(rnd);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_valid_reg <= 1'b0;
            height_latched_reg <= 1'b0;
            refh_reg <= '0;
            for (int i = 0; i < 12; i++) base_reg[i] <= '0;
        end else begin
            if (ctrl.clr_base) base_valid_reg <= 1'b0;
            if (ctrl.clr_height) height_latched_reg <= 1'b0;
            if (ctrl.capture && stat.moved) begin
                for (int i = 0; i < 12; i++) base_reg[i] <= cam_reg[i];
                base_valid_reg <= 1'b1;
            end
            if (ctrl.remap && k == 2'd2 && !height_latched_reg) begin
                refh_reg <= pose_reg[7];
                height_latched_reg <= 1'b1;
            end
        end
    end

    assign res_value = res_reg;
endmodule

FILE: rtl/hpc_ctrl.sv
// sequencer for loads, base capture, remap, scaling and output elements
`timescale 1ns / 1ps
module hpc_ctrl
    import hpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_opcode,
    input  logic [3:0]  s_element_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_result_index,
    output logic        m_last_element,
    output ctrl_t       ctrl
);
    state_t     state_reg, state_next;
    logic [1:0] sub_reg, sub_next;
    logic [3:0] ri_reg, ri_next;
    logic       take, sc_round_reg, sc_round_next;

    assign take = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sub_reg <= '0;
            ri_reg <= '0;
            sc_round_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sub_reg <= sub_next;
            ri_reg <= ri_next;
            sc_round_reg <= sc_round_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        sub_next = sub_reg;
        ri_next = ri_reg;
        sc_round_next = 1'b0;
        ctrl = '0;
        ctrl.sub = sub_reg;
        ctrl.res_idx = ri_reg;
        s_ready = (state_reg == ST_IDLE);
        m_valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    ctrl.load_pose = (s_opcode == OP_LOAD_POSE) && (s_element_index < 4'd12);
                    ctrl.load_cam = (s_opcode == OP_LOAD_CAM) && (s_element_index < 4'd12);
                    ctrl.clr_base = (s_opcode == OP_RESET_BASE);
                    ctrl.clr_height = (s_opcode == OP_RECAL);
                    if (s_opcode == OP_COMPUTE) begin
                        ctrl.dist_clr = 1'b1;
                        sub_next = '0;
                        state_next = ST_DIST;
                    end
                end
            end
            ST_DIST: begin
                ctrl.dist_step = 1'b1;
                sub_next = sub_reg + 2'd1;
                if (sub_reg == 2'd2) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                ctrl.capture = 1'b1;
                sub_next = '0;
                state_next = ST_REMAP;
            end
            ST_REMAP: begin
                ctrl.remap = 1'b1;
                sub_next = sub_reg + 2'd1;
                if (sub_reg == 2'd2) begin
                    sub_next = '0;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                // multiply one axis, then round it on the next pass
                ctrl.scale = 1'b1;
                ctrl.round_res = sc_round_reg;
                sc_round_next = !sc_round_reg;
                if (sc_round_reg) begin
                    sub_next = sub_reg + 2'd1;
                    if (sub_reg == 2'd2) begin
                        sub_next = '0;
                        ri_next = '0;
                        ctrl.mac_clr = 1'b1;
                        state_next = ST_MAC;
                    end
                end
            end
            ST_MAC: begin
                ctrl.mac_step = 1'b1;
                sub_next = sub_reg + 2'd1;
                if ((ri_reg < 4'd9 && sub_reg == 2'd2) || sub_reg == 2'd3) begin
                    sub_next = '0;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                ctrl.round_res = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    ctrl.mac_clr = 1'b1;
                    ri_next = ri_reg + 4'd1;
                    state_next = (ri_reg == 4'd11) ? ST_IDLE : ST_MAC;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_result_index = ri_reg;
    assign m_last_element = (ri_reg == 4'd11);

    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ri_reg < 4'd12) else $error("result index out of range");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready) else $error("accept while busy");
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_element) |=> state_reg == ST_IDLE)
        else $error("sequence not closed after last word");
endmodule

FILE: rtl/hmd_pose_to_camera_transform.sv
// top level: config registers, controller and datapath
//   channel | direction | fields
//   s_      | in        | opcode, element_index, element_value
//   m_      | out       | result_index, result_value, last_element
//   cfg_    | in        | write enable, index, data
// loads and flag commands are accepted in idle; a compute holds off input while it
// runs the distance check, capture, remap and scaling, and then works out each
// rotation and translation word in turn on the shared mac.
// each result word waits in the output register until taken; the block holds
// off input until the twelfth word goes. reset is synchronous, active low.
`timescale 1ns / 1ps
module hmd_pose_to_camera_transform
    import hpc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_opcode,
    input  logic [3:0]         s_element_index,
    input  logic signed [31:0] s_element_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_result_index,
    output logic signed [31:0] m_result_value,
    output logic               m_last_element,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [30:0]        cfg_data
);
    logic [30:0] upm_reg, tel_reg;
    ctrl_t ctrl;
    stat_t stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upm_reg <= UPM_RESET;
            tel_reg <= TELEPORT_RESET;
        end else if (cfg_we) begin
            if (cfg_index == REG_UPM) upm_reg <= cfg_data;
            else tel_reg <= cfg_data;
        end
    end

    hpc_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_opcode, .s_element_index,
        .m_valid, .m_ready, .m_result_index, .m_last_element, .ctrl
    );

    hpc_datapath u_dp (
        .aclk, .aresetn, .ctrl, .idx(s_element_index), .value(s_element_value),
        .upm(upm_reg), .teleport(tel_reg), .stat, .res_value(m_result_value)
    );
endmodule

FILE: verif/hmd_pose_to_camera_transform_tb.sv
// testbench for the headset pose to camera transform: scoreboard predicts every output word
`timescale 1ns / 1ps
module hmd_pose_to_camera_transform_tb;
    import hpc_pkg::*;

    localparam int FB = 16;
    localparam int MAX_CYCLES = 1000000;

    typedef struct packed {
        logic [3:0]         idx;
        logic signed [31:0] val;
        logic               last;
    } word_t;

    // predicts the transform words and holds them until they come out
    class transform_board;
        logic signed [31:0] pose[12];
        logic signed [31:0] cam[12];
        logic signed [31:0] base[12];
        bit                 base_held;
        logic signed [31:0] ref_h;
        bit                 h_held;
        logic [30:0]        upm;
        logic [30:0]        tele;
        word_t              pending[$];
        int                 errors;

        function new();
            foreach (pose[i]) begin
                pose[i] = 0;
                cam[i] = 0;
                base[i] = 0;
            end
            base_held = 0;
            ref_h = 0;
            h_held = 0;
            upm = UPM_RESET;
            tele = TELEPORT_RESET;
            errors = 0;
        endfunction

        function longint clip(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // exact sum over 2^FB, round half up, saturate (terms within 2^62)
        function longint round_sum(longint t[4], int n);
            longint q, r, x;
            q = 0;
            r = 0;
            for (int i = 0; i < n; i++) begin
                q += t[i] >>> 2;
                r += t[i] - ((t[i] >>> 2) * 4);
            end
            x = q + (64'sd1 <<< (FB - 3)) + (r >>> 2);
            return clip(x >>> (FB - 2));
        endfunction

        function bit jumped();
            longint unsigned d, s, t;
            s = 0;
            t = tele;
            for (int i = 9; i < 12; i++) begin
                longint dd;
                dd = longint'(cam[i]) - longint'(base[i]);
                d = dd < 0 ? -dd : dd;
                if (d > t) return 1;
                s += d * d;
            end
            return s > t * t;
        endfunction

        function void write_reg(reg_index_t i, logic [30:0] v);
            if (i == REG_UPM) upm = v;
            else tele = v;
        endfunction

        function void note_input(logic [2:0] op, logic [3:0] ix, logic signed [31:0] v);
            longint hr[9], ht[3], t[4], res[12], dl;
            case (op)
                OP_LOAD_POSE: if (ix < 12) pose[ix] = v;
                OP_LOAD_CAM:  if (ix < 12) cam[ix] = v;
                OP_RESET_BASE: base_held = 0;
                OP_RECAL:     h_held = 0;
                OP_COMPUTE: begin
                    if (!base_held || jumped()) begin
                        base = cam;
                        base_held = 1;
                    end
                    for (int r = 0; r < 3; r++) begin
                        hr[r*3]   = pose[r*4];
                        hr[r*3+1] = clip(-longint'(pose[r*4+2]));
                        hr[r*3+2] = pose[r*4+1];
                    end
                    if (!h_held) begin
                        ref_h = pose[7];
                        h_held = 1;
                    end
                    dl = clip(longint'(pose[7]) - longint'(ref_h));
                    t[0] = longint'(pose[3]) * longint'(upm);
                    ht[0] = round_sum(t, 1);
                    t[0] = -longint'(pose[11]) * longint'(upm);
                    ht[1] = round_sum(t, 1);
                    t[0] = dl * longint'(upm);
                    ht[2] = round_sum(t, 1);
                    for (int r = 0; r < 3; r++) begin
                        for (int c = 0; c < 3; c++) begin
                            for (int k = 0; k < 3; k++)
                                t[k] = longint'(base[r*3+k]) * hr[k*3+c];
                            res[r*3+c] = round_sum(t, 3);
                        end
                        for (int k = 0; k < 3; k++)
                            t[k] = longint'(base[r*3+k]) * ht[k];
                        t[3] = longint'(base[9+r]) <<< FB;
                        res[9+r] = round_sum(t, 4);
                    end
                    for (int k = 0; k < 12; k++)
                        pending.push_back('{4'(k), 32'(res[k]), k == 11});
                end
                default: ;
            endcase
        endfunction

        function void check_word(word_t got);
            word_t w;
            if (pending.size() == 0) begin
                $error("unexpected word idx=%0d val=%0d", got.idx, got.val);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.idx !== w.idx) begin
                $error("result_index: expected %0d actual %0d", w.idx, got.idx);
                errors++;
            end
            if (got.val !== w.val) begin
                $error("result_value: expected %0d actual %0d", w.val, got.val);
                errors++;
            end
            if (got.last !== w.last) begin
                $error("last_element: expected %0d actual %0d", w.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [2:0]         s_opcode;
    logic [3:0]         s_element_index;
    logic signed [31:0] s_element_value;
    logic               m_valid;
    logic               m_ready;
    logic [3:0]         m_result_index;
    logic signed [31:0] m_result_value;
    logic               m_last_element;
    logic               cfg_we;
    logic               cfg_index;
    logic [30:0]        cfg_data;

    transform_board board;
    bit             calm;
    int             cycles;
    int             stall;

    hmd_pose_to_camera_transform u_top (.*);

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    // output side: stalls at random in bursts unless calm, checks every taken word
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
            stall = 0;
        end else begin
            if (m_valid && m_ready)
                board.check_word('{m_result_index, m_result_value, m_last_element});
            if (calm) begin
                m_ready <= 1;
            end else if (stall > 0) begin
                stall = stall - 1;
                m_ready <= 0;
            end else if ($urandom_range(0, 3) == 0) begin
                stall = $urandom_range(0, 8);
                m_ready <= 0;
            end else begin
                m_ready <= 1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > MAX_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send(logic [2:0] op, logic [3:0] ix, logic signed [31:0] v);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_opcode <= op;
        s_element_index <= ix;
        s_element_value <= v;
        do @(posedge aclk); while (!s_ready);
        board.note_input(op, ix, v);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic set_reg(reg_index_t i, logic [30:0] v);
        drain();
        cfg_we <= 1;
        cfg_index <= i;
        cfg_data <= v;
        @(posedge aclk);
        cfg_we <= 0;
        board.write_reg(i, v);
    endtask

    function automatic logic signed [31:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom_range(0, 1) ? 32'sh00010000 : -32'sh00010000;
            3: return $signed($urandom) >>> $urandom_range(8, 24);
            default: return $urandom;
        endcase
    endfunction

    // full pose and, if with_cam, camera, then compute
    task automatic frame(bit with_cam);
        for (int i = 0; i < 12; i++) send(OP_LOAD_POSE, 4'(i), rand_val());
        if (with_cam)
            for (int i = 0; i < 12; i++) send(OP_LOAD_CAM, 4'(i), rand_val());
        send(OP_COMPUTE, '0, '0);
    endtask

    initial begin
        board = new();
        calm = 0;
        cycles = 0;
        aresetn = 0;
        s_valid = 0;
        s_opcode = OP_LOAD_POSE;
        s_element_index = 0;
        s_element_value = 0;
        cfg_we = 0;
        cfg_index = REG_UPM;
        cfg_data = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extremes, ignored loads, unused opcodes, flag commands
        for (int i = 0; i < 12; i++) send(OP_LOAD_POSE, 4'(i), i[0] ? 32'sh80000000 : 32'sh7fffffff);
        for (int i = 0; i < 12; i++) send(OP_LOAD_CAM, 4'(i), i[1] ? 32'sh80000000 : 32'sh7fffffff);
        send(OP_LOAD_POSE, 4'd15, 32'sh7fffffff);
        send(OP_LOAD_CAM, 4'd12, 32'sh80000000);
        send(3'd5, 4'd3, '0);
        send(3'd7, 4'd15, -1);
        send(OP_COMPUTE, '0, '0);
        send(OP_COMPUTE, '0, '0);
        send(OP_RESET_BASE, '0, '0);
        send(OP_RECAL, '0, '0);
        send(3'd6, '0, '0);
        send(OP_COMPUTE, '0, '0);

        set_reg(REG_UPM, 31'h7fffffff);
        set_reg(REG_TELEPORT, 31'd0);
        for (int n = 0; n < 2; n++) frame(1);
        set_reg(REG_UPM, 31'd0);
        set_reg(REG_TELEPORT, 31'h7fffffff);
        for (int n = 0; n < 2; n++) frame(n[0]);

        // random phases: mostly full frames, some noise and extra commands
        for (int ph = 0; ph < 2; ph++) begin
            set_reg(REG_UPM, 31'($urandom_range(0, 32'h7fffffff) >> $urandom_range(0, 12)));
            set_reg(REG_TELEPORT,
                    31'($urandom_range(0, 32'h7fffffff) >> $urandom_range(0, 14)));
            for (int n = 0; n < 2; n++) begin
                case ($urandom_range(0, 5))
                    0: send(OP_RESET_BASE, 4'($urandom), $urandom);
                    1: send(OP_RECAL, 4'($urandom), $urandom);
                    2: send(3'($urandom_range(5, 7)), 4'($urandom), $urandom);
                    3: send(3'($urandom_range(0, 1)), 4'($urandom_range(12, 15)), $urandom);
                    default: ;
                endcase
                if ($urandom_range(0, 2) == 0)
                    for (int i = 0; i < 4; i++)
                        send(3'($urandom_range(0, 1)), 4'($urandom_range(0, 11)), rand_val());
                frame($urandom_range(0, 2) != 0);
            end
            if (ph == 1) drain();
        end
        set_reg(REG_UPM, UPM_RESET);
        set_reg(REG_TELEPORT, TELEPORT_RESET);
        calm = 1;
        for (int n = 0; n < 2; n++) frame(1);

        drain();
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/hpc_pkg.sv
rtl/hpc_datapath.sv
rtl/hpc_ctrl.sv
rtl/hmd_pose_to_camera_transform.sv
verif/hmd_pose_to_camera_transform_tb.sv
